// ===== design/tfa_pkg.sv =====
// tfa_pkg: sizes, field layout and shared types of the thermocouple frame averager
// no dependencies; imported by every module of the block

package tfa_pkg;

  // block size
  localparam int CHANNELS = 2;
  localparam int WINDOW   = 4;

  // field widths
  localparam int CH_W      = 1;
  localparam int CFG_W     = 2;
  localparam int FRAME_W   = 16;
  localparam int CODE_LSB  = 3;
  localparam int CODE_W    = FRAME_W - CODE_LSB;
  localparam int OPEN_BIT  = 2;
  localparam int AVG_W     = 17;
  localparam int PRESENT_W = 2;
  localparam int ERR_W     = 32;

  // stream word layout, lowest bit first
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;

  // derived storage sizes
  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W    = $clog2(WINDOW + 1);
  localparam int SUM_W     = $clog2(WINDOW * ((1 << CODE_W) - 1) + 1);
  localparam int DIVD_W    = SUM_W + 2;
  localparam int WIN_DEPTH = CHANNELS * WINDOW;
  localparam int WADDR_W   = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  // per-channel bookkeeping entry
  typedef struct packed {
    logic [FILL_W-1:0] fill;
    logic [PTR_W-1:0]  ptr;
    logic [SUM_W-1:0]  sum;
  } tfa_meta_t;

  // access requests from the sequencer to the storage
  typedef struct packed {
    logic               meta_rd;
    logic [CH_AW-1:0]   meta_rd_ch;
    logic               win_rd;
    logic [WADDR_W-1:0] win_rd_addr;
    logic               wr;
    logic [CH_AW-1:0]   wr_ch;
    logic [WADDR_W-1:0] win_wr_addr;
  } tfa_store_req_t;

endpackage

// ===== design/thermocouple_frame_averager_unit.sv =====
// thermocouple_frame_averager_unit: top level, sequencer, counters and output register
// depends on tfa_pkg, tfa_store and tfa_divider
//
// One frame is handled at a time. A frame for a disabled channel or with a failed
// transfer goes from S_IDLE straight to S_DONE; a good frame with the open-junction
// bit passes S_META and S_WIN; a good closed frame also waits in S_DIV for the
// bit-serial divider that forms the window average. Each frame gives exactly one
// result. The result sits in an output register, so the next frame is taken while
// it waits. s_axis_tuser carries the channel; s_axis_tdata bit 0 is the transfer-ok
// flag and bits 16:1 the raw converter word. The user must write the enable mask through
// cfg_we_i / cfg_wdata_i only while no frame is in flight; the block does not enforce it.

module thermocouple_frame_averager_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tfa_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [23:17] zero, [16:1] frame, [0] transfer_ok
  input  logic [tfa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] channel
  input  logic [tfa_pkg::CH_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [55:53] zero, [52:21] error_count, [20:19] present_mask,
  // [18:2] average_sixteenths, [1] temperature_valid, [0] accepted
  output logic [tfa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] result_channel
  output logic [tfa_pkg::CH_W-1:0]        m_axis_tuser
);
  import tfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_META = 5'b00010,
    S_WIN  = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } tfa_state_e;

  typedef struct packed {
    logic [CH_W-1:0]      chan;
    logic                 accepted;
    logic                 temp_valid;
    logic [AVG_W-1:0]     avg;
    logic [PRESENT_W-1:0] present;
    logic [ERR_W-1:0]     err;
  } tfa_result_t;

  tfa_state_e           st_q, st_d;
  logic [CHANNELS-1:0]  mask_q;
  logic [CHANNELS-1:0]  present_q, present_d;
  logic [ERR_W-1:0]     err_q, err_d;
  logic                 out_vld_q, out_vld_d;
  tfa_result_t          out_q, out_d;

  logic [CH_W-1:0]      ch_q;
  logic                 ok_q, en_q, open_q;
  logic [FRAME_W-1:0]   frame_q;
  logic [AVG_W-1:0]     avg_q, avg_d;
  tfa_meta_t            meta_q;
  logic                 full_q;
  logic [PTR_W-1:0]     p_q;
  logic [WADDR_W-1:0]   addr_q;

  logic                 in_acc;
  logic [CH_W-1:0]      in_ch;
  logic [CH_AW-1:0]     in_ch_idx, ch_idx;
  logic                 in_en;
  logic [CODE_W-1:0]    code;
  logic [PTR_W-1:0]     p_rd;
  tfa_meta_t            meta_new;
  logic [SUM_W-1:0]     old_val;
  logic                 out_free;

  tfa_store_req_t       req;
  tfa_meta_t            rd_meta;
  logic [CODE_W-1:0]    rd_code;
  logic                 div_start, div_done;
  logic [DIVD_W-1:0]    div_quo;

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_ch     = s_axis_tuser;
  assign in_ch_idx = CH_AW'(in_ch);
  assign ch_idx    = CH_AW'(ch_q);
  assign in_en     = (32'(in_ch) < CHANNELS) ? mask_q[in_ch_idx] : 1'b0;
  assign code      = frame_q[FRAME_W-1:CODE_LSB];
  assign out_free  = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (st_q == S_IDLE);

  // stored pointer never reaches the window depth, the wrap is only a guard
  assign p_rd = (32'(rd_meta.ptr) >= WINDOW) ? '0 : rd_meta.ptr;

  assign old_val       = full_q ? SUM_W'(rd_code) : '0;
  assign meta_new.sum  = SUM_W'(meta_q.sum - old_val + SUM_W'(code));
  assign meta_new.fill = full_q ? meta_q.fill : FILL_W'(meta_q.fill + 1'b1);
  assign meta_new.ptr  = (p_q == PTR_W'(WINDOW - 1)) ? '0 : PTR_W'(p_q + 1'b1);

  always_comb begin
    req             = '0;
    req.meta_rd     = in_acc;
    req.meta_rd_ch  = in_ch_idx;
    req.win_rd      = (st_q == S_META);
    req.win_rd_addr = WADDR_W'(32'(ch_idx) * WINDOW + 32'(p_rd));
    req.wr          = (st_q == S_WIN);
    req.wr_ch       = ch_idx;
    req.win_wr_addr = addr_q;
  end

  assign div_start = (st_q == S_WIN) && !open_q;

  always_comb begin
    st_d      = st_q;
    present_d = present_q;
    err_d     = err_q;
    avg_d     = avg_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    unique case (st_q)
      S_IDLE: begin
        if (in_acc) begin
          avg_d = '0;
          st_d  = (in_en && s_axis_tdata[0]) ? S_META : S_DONE;
          if (in_en && !s_axis_tdata[0] && (err_q != '1)) begin
            err_d = ERR_W'(err_q + 1'b1);
          end
        end
      end
      S_META: st_d = S_WIN;
      S_WIN: begin
        if (open_q) begin
          present_d = present_q & ~(CHANNELS'(1) << ch_idx);
          st_d      = S_DONE;
        end else begin
          present_d = present_q | (CHANNELS'(1) << ch_idx);
          st_d      = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          avg_d = AVG_W'(div_quo);
          st_d  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_d        = 1'b1;
          out_d.chan       = ch_q;
          out_d.accepted   = en_q && ok_q;
          out_d.temp_valid = en_q && ok_q && !open_q;
          out_d.avg        = avg_q;
          out_d.present    = PRESENT_W'(present_q);
          out_d.err        = err_q;
          st_d             = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      mask_q    <= '0;
      present_q <= '0;
      err_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      present_q <= present_d;
      err_q     <= err_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        mask_q <= CHANNELS'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    avg_q <= avg_d;
    if (in_acc) begin
      ch_q    <= in_ch;
      ok_q    <= s_axis_tdata[0];
      en_q    <= in_en;
      frame_q <= s_axis_tdata[FRAME_W:1];
      open_q  <= s_axis_tdata[OPEN_BIT+1];
    end
    if (st_q == S_META) begin
      meta_q <= rd_meta;
      full_q <= (32'(rd_meta.fill) >= WINDOW);
      p_q    <= p_rd;
      addr_q <= req.win_rd_addr;
    end
  end

  tfa_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .wr_meta_i (meta_new),
    .wr_code_i (code),
    .rd_meta_o (rd_meta),
    .rd_code_o (rd_code)
  );

  tfa_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({meta_new.sum, 2'b00}),
    .divisor_i  (meta_new.fill),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.chan;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.err, out_q.present, out_q.avg,
                                       out_q.temp_valid, out_q.accepted});

  // the divider is never started with an empty window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> (meta_new.fill != '0))
    else $error("divider started with zero fill");

  // the failure counter only moves up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (err_q >= $past(err_q)))
    else $error("error count went down");

  // window writes only for enabled channels with a good transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.wr |-> (en_q && ok_q))
    else $error("window written for a rejected frame");

  // a valid temperature is always from an accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.temp_valid) |-> out_q.accepted)
    else $error("valid temperature without accepted sample");

endmodule

// ===== design/tfa_divider.sv =====
// tfa_divider: restoring divider, one quotient bit per cycle
// depends on tfa_pkg for operand widths

module tfa_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tfa_pkg::DIVD_W-1:0] dividend_i,
  input  logic [tfa_pkg::FILL_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [tfa_pkg::DIVD_W-1:0] quotient_o
);
  import tfa_pkg::*;

  localparam int CNT_W = (DIVD_W > 1) ? $clog2(DIVD_W) : 1;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [FILL_W-1:0] rem_q, rem_d;
  logic [FILL_W-1:0] dvs_q, dvs_d;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [FILL_W:0]   trial;
  logic              fits;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? FILL_W'(trial - {1'b0, dvs_q}) : FILL_W'(trial);
      quo_d = {quo_q[DIVD_W-2:0], fits};
      cnt_d = CNT_W'(cnt_q + 1'b1);
      if (cnt_q == CNT_W'(DIVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/tfa_store.sv =====
// tfa_store: sample window memory and per-channel bookkeeping memory
// depends on tfa_pkg for entry types and sizes; both reads are registered

module tfa_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tfa_pkg::tfa_store_req_t    req_i,
  input  tfa_pkg::tfa_meta_t         wr_meta_i,
  input  logic [tfa_pkg::CODE_W-1:0] wr_code_i,
  output tfa_pkg::tfa_meta_t         rd_meta_o,
  output logic [tfa_pkg::CODE_W-1:0] rd_code_o
);
  import tfa_pkg::*;

  logic [CODE_W-1:0]   win_mem [WIN_DEPTH];
  tfa_meta_t           meta_mem [CHANNELS];
  logic [CHANNELS-1:0] meta_vld_q;
  logic                rd_vld_q;
  tfa_meta_t           meta_rd_q;
  logic [CODE_W-1:0]   code_rd_q;

  // bookkeeping reads as zero until the channel's entry is first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (req_i.wr) begin
        meta_vld_q[req_i.wr_ch] <= 1'b1;
      end
      if (req_i.meta_rd) begin
        rd_vld_q <= meta_vld_q[req_i.meta_rd_ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      meta_mem[req_i.wr_ch]      <= wr_meta_i;
      win_mem[req_i.win_wr_addr] <= wr_code_i;
    end
    if (req_i.meta_rd) begin
      meta_rd_q <= meta_mem[req_i.meta_rd_ch];
    end
    if (req_i.win_rd) begin
      code_rd_q <= win_mem[req_i.win_rd_addr];
    end
  end

  assign rd_meta_o = rd_vld_q ? meta_rd_q : '0;
  assign rd_code_o = code_rd_q;

endmodule
